// ===== sv/mel_pkg.sv =====
// Shared types and constants for the recency list block.
`timescale 1ns / 1ps

package mel_pkg;

  localparam int unsigned POS_W   = 64;
  localparam int unsigned LIMIT_W = 7;

  // One readout result as it moves from the list walker to the output buffer.
  typedef struct packed {
    logic [POS_W-1:0]   entry;
    logic               entry_valid;
    logic               last;
    logic [LIMIT_W-1:0] count;
  } mel_result_t;

  // Occupancy of the output buffer as seen by the walker.
  typedef struct packed {
    logic [1:0] held;
    logic       fire;
  } mel_obuf_stat_t;

endpackage

// ===== sv/mel_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mel_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mel_pkg::POS_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [mel_pkg::POS_W-1:0] rdata
);
  import mel_pkg::*;

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mel_out.sv =====
// Output register with a skid stage for readout results.
`timescale 1ns / 1ps

module mel_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             arr_valid,
  input  mel_pkg::mel_result_t             arr_data,
  output mel_pkg::mel_obuf_stat_t          stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [71:0]                      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);
  import mel_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  mel_result_t out_r, out_nxt;
  mel_result_t skid_r, skid_nxt;
  logic        fire;

  assign fire = out_valid_r & out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || fire) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = arr_data;
        skid_valid_nxt = arr_valid;
      end else begin
        out_nxt       = arr_data;
        out_valid_nxt = arr_valid;
      end
    end else if (arr_valid) begin
      skid_nxt       = arr_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign stat.held  = {1'b0, out_valid_r} + {1'b0, skid_valid_r};
  assign stat.fire  = fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.count, out_r.entry};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.entry_valid;

endmodule

// ===== sv/mru_exclusion_list.sv =====
// Top level of the recency list: control sequencer around the entry store.
//
//   Channel  | Direction | Transaction carries
//   ---------+-----------+------------------------------------------------------
//   in_      | slave     | tdata: position[63:0]; tuser: kind[0], is_real[1]
//   out_     | master    | tdata: entry[63:0], count[70:64]; tuser: entry_valid;
//            |           | tlast: last
//   cfg_     | slave     | data: keep_limit[6:0]
//
// The list is a ring in one memory with a registered read port; the search,
// compaction and readout walk it one entry per cycle, the readout only while
// the output buffer has room. An insert into a non-empty list runs the match
// search, the shift of newer entries down by one (only when the position was
// already held), and the trim and append. An insert into an empty list goes
// straight to the append; under a zero limit an insert just empties the list,
// and a skipped one returns to idle. A readout first trims to the limit;
// output stalls pause the memory reads through a two-deep output buffer.
// After reset the list is empty and keep_limit is 64; no clearing pass is needed.
`timescale 1ns / 1ps

module mru_exclusion_list #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // position[63:0]
  input  logic [1:0]  in_tuser,   // kind[0], is_real[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // entry[63:0], count[70:64], zero[71]
  output logic        out_tlast,
  output logic        out_tuser,  // entry_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // keep_limit[6:0]
);
  import mel_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPACT,
    S_APPEND,
    S_TRIM,
    S_READ
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      rd_at_r, rd_at_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic [LIMIT_W-1:0] keep_limit_r;

  logic [CW-1:0]      lim;
  logic [CW-1:0]      keep_cnt;
  logic [AW-1:0]      trim_head;
  logic               in_fire;
  logic               credit_ok;
  logic               issue;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [POS_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [POS_W-1:0]   mem_rdata;

  logic               arr_valid;
  mel_result_t        arr_data;
  mel_obuf_stat_t     obuf_stat;

  // Ring address of logical slot ofs; the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_addr(logic [AW-1:0] base, logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(ofs);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign lim = (keep_limit_r > LIMIT_W'(DEPTH)) ? CW'(DEPTH) : CW'(keep_limit_r);

  // An insert keeps room for the new position; a readout trims to the limit.
  always_comb begin
    if (state_r == S_APPEND) begin
      keep_cnt = (cnt_r > lim - 1'b1) ? lim - 1'b1 : cnt_r;
    end else begin
      keep_cnt = (cnt_r > lim) ? lim : cnt_r;
    end
  end
  assign trim_head = ring_addr(head_r, cnt_r - keep_cnt);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  // Pending read data counts against the two output slots.
  always_comb begin
    logic [1:0] occ;
    occ = obuf_stat.held + {1'b0, rd_v_r};
    credit_ok = (occ < 2'd2) || ((occ == 2'd2) && obuf_stat.fire);
  end

  always_comb begin
    case (state_r)
      S_SEARCH, S_COMPACT: issue = (rd_idx_r < cnt_r);
      S_READ:              issue = (rd_idx_r < cnt_r) && credit_ok;
      default:             issue = 1'b0;
    endcase
  end
  assign mem_raddr = ring_addr(head_r, rd_idx_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ring_addr(head_r, rd_at_r - 1'b1);
    mem_wdata = mem_rdata;
    if (state_r == S_COMPACT && rd_v_r) begin
      mem_we = 1'b1;
    end else if (state_r == S_APPEND) begin
      mem_we    = 1'b1;
      mem_waddr = ring_addr(trim_head, keep_cnt);
      mem_wdata = pos_r;
    end
  end

  always_comb begin
    arr_valid            = 1'b0;
    arr_data.entry       = mem_rdata;
    arr_data.entry_valid = 1'b1;
    arr_data.last        = (rd_at_r == cnt_r - 1'b1);
    arr_data.count       = LIMIT_W'(cnt_r);
    if (state_r == S_READ) begin
      if (cnt_r == '0) begin
        arr_valid            = credit_ok;
        arr_data.entry       = '0;
        arr_data.entry_valid = 1'b0;
        arr_data.last        = 1'b1;
      end else begin
        arr_valid = rd_v_r;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    rd_idx_nxt = issue ? rd_idx_r + 1'b1 : rd_idx_r;
    rd_v_nxt   = issue;
    rd_at_nxt  = issue ? rd_idx_r : rd_at_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt    = in_tdata;
          rd_idx_nxt = '0;
          if (in_tuser[0]) begin
            state_nxt = S_TRIM;
          end else if (!in_tuser[1]) begin
            if (lim == '0) begin
              cnt_nxt = '0;
            end else if (cnt_r == '0) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (rd_v_r && mem_rdata == pos_r) begin
          // Reads already under way feed the compaction directly.
          state_nxt = S_COMPACT;
        end else if (rd_v_r && rd_at_r == cnt_r - 1'b1) begin
          state_nxt = S_APPEND;
        end
      end
      S_COMPACT: begin
        if (rd_idx_r == cnt_r && !rd_v_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        head_nxt  = trim_head;
        cnt_nxt   = keep_cnt + 1'b1;
        state_nxt = S_IDLE;
      end
      S_TRIM: begin
        head_nxt   = trim_head;
        cnt_nxt    = keep_cnt;
        rd_idx_nxt = '0;
        state_nxt  = S_READ;
      end
      S_READ: begin
        if (cnt_r == '0) begin
          if (credit_ok) begin
            state_nxt = S_IDLE;
          end
        end else if (rd_idx_r == cnt_r && !rd_v_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      head_r       <= '0;
      rd_v_r       <= 1'b0;
      rd_idx_r     <= '0;
      keep_limit_r <= LIMIT_W'(64);
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      rd_v_r   <= rd_v_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_limit_r <= cfg_data;
      end
    end
    pos_r   <= pos_nxt;
    rd_at_r <= rd_at_nxt;
  end

  mel_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mel_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .arr_valid  (arr_valid),
    .arr_data   (arr_data),
    .stat       (obuf_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The list never holds more than the store can.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // A result never arrives when both output slots are held and none leaves.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (obuf_stat.held == 2'd2 && !obuf_stat.fire) |-> !arr_valid)
    else $error("output buffer overflow");

  // Compaction writes always trail the read address.
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && issue) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same entry");

endmodule
